@@ design/rmdr_pkg.sv @@
// ============================================================================
// Rational multiply/divide/reduce package
// Shared constants, codes and controller/datapath interface structs.
// ============================================================================
`default_nettype none

package rmdr_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int PROD_W      = 2 * IN_W;
    localparam int CNT_W       = $clog2(PROD_W);
    localparam int SHIFT_W     = $clog2(PROD_W) + 1;

    typedef enum logic [1:0] {
        OP_REDUCE = 2'd0,
        OP_MUL    = 2'd1,
        OP_DIV    = 2'd2,
        OP_EQ     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic mul_first;
        logic mul_second;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic zero_den;
        logic is_eq;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ design/rational_mul_div_reduce.sv @@
// ============================================================================
// Rational multiply/divide/reduce unit
// Reduces, multiplies or divides fractions via binary gcd; compares two by cross products.
// ============================================================================
//  Channel | Group         | Contents
//  input   | s_tvalid ...  | tdata: a_num, a_den, b_num, b_den; tuser: req_type
//  output  | m_tvalid ...  | tdata: res_num, res_den, is_equal; tuser: status
//
//  One transaction at a time: multiply, then binary gcd on the 64-bit products,
//  then the dual restoring divider; zero-denominator requests skip to output
//  and equality tests end after the cross products.
//  The gcd loop and the bit-serial divider are iterative.
//  A finished result waits in the output register while the next is accepted.
//  Reset clears control only; no clearing pass.
// ============================================================================
`default_nettype none

module rational_mul_div_reduce
#(
    parameter int VALUE_WIDTH = rmdr_pkg::VALUE_WIDTH
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [127:0]  s_tdata,   // a_num, a_den, b_num, b_den
    input  wire [1:0]    s_tuser,   // req_type
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [63:0]  m_tdata,   // res_num, res_den, is_equal
    output logic [1:0]   m_tuser    // status
);

    rmdr_pkg::cmd_t cmd;
    rmdr_pkg::sts_t sts;
    logic [31:0]    res_num;
    logic [30:0]    res_den;
    logic           is_equal;

    rmdr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rmdr_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_type    (s_tuser),
        .in_a_num   (s_tdata[31:0]),
        .in_a_den   (s_tdata[63:32]),
        .in_b_num   (s_tdata[95:64]),
        .in_b_den   (s_tdata[127:96]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_num    (res_num),
        .out_den    (res_den),
        .out_eq     (is_equal),
        .out_status (m_tuser)
    );

    assign m_tdata = {is_equal, res_den, res_num};

endmodule

`default_nettype wire

@@ design/rmdr_ctrl.sv @@
// ============================================================================
// Rational unit controller
// Sequences multiply, binary gcd and the two divisions for one transaction.
// ============================================================================
`default_nettype none

module rmdr_ctrl
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  rmdr_pkg::sts_t  sts,
    output rmdr_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MULA  = 7'b0000010,
        S_MULB  = 7'b0000100,
        S_GINIT = 7'b0001000,
        S_GCD   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULA;
                end
            end
            S_MULA:
            begin
                cmd.mul_first = 1'b1;
                state_next    = sts.zero_den ? S_FIN : S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_second = 1'b1;
                state_next     = S_GINIT;
            end
            S_GINIT:
            begin
                // equality needs only the cross products
                if (sts.is_eq)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = S_GCD;
                end
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/rmdr_dp.sv @@
// ============================================================================
// Rational unit datapath
// Shared multiplier, binary gcd, dual restoring divider and output register.
// ============================================================================
`default_nettype none

module rmdr_dp
#(
    parameter int VALUE_WIDTH = rmdr_pkg::VALUE_WIDTH
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  rmdr_pkg::cmd_t               cmd,
    output rmdr_pkg::sts_t               sts,
    input  wire [1:0]                    in_type,
    input  wire [rmdr_pkg::IN_W-1:0]     in_a_num,
    input  wire [rmdr_pkg::IN_W-1:0]     in_a_den,
    input  wire [rmdr_pkg::IN_W-1:0]     in_b_num,
    input  wire [rmdr_pkg::IN_W-1:0]     in_b_den,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [31:0]                  out_num,
    output logic [30:0]                  out_den,
    output logic                         out_eq,
    output logic [1:0]                   out_status
);

    localparam int W  = rmdr_pkg::IN_W;
    localparam int PW = rmdr_pkg::PROD_W;
    localparam logic [PW-1:0] LIMIT = PW'(1) << (VALUE_WIDTH - 1);

    rmdr_pkg::op_t op_reg;
    logic [W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic          neg_reg, sign_ok_reg, zero_reg;
    logic [PW-1:0] p_reg, q_reg, u_reg, v_reg, g_reg, rn_reg, rd_reg;
    logic [rmdr_pkg::SHIFT_W-1:0] k_reg;
    logic [rmdr_pkg::CNT_W-1:0]   cnt_reg;
    logic          valid_reg;
    logic [31:0]   num_reg;
    logic [30:0]   den_reg;
    logic          eq_reg;
    rmdr_pkg::status_t status_reg;

    logic [W-1:0]  an_m, ad_m, bn_m, bd_m;
    logic          as_s, bs_s;
    rmdr_pkg::op_t in_op;
    logic [W-1:0]  mx, my;
    logic [PW-1:0] prod;
    logic [PW:0]   rn_sh, rd_sh;
    logic          bit_n, bit_d;
    logic          r_neg, r_ovf;

    assign in_op = rmdr_pkg::op_t'(in_type);
    assign an_m  = in_a_num[W-1] ? (~in_a_num + 1'b1) : in_a_num;
    assign ad_m  = in_a_den[W-1] ? (~in_a_den + 1'b1) : in_a_den;
    assign bn_m  = in_b_num[W-1] ? (~in_b_num + 1'b1) : in_b_num;
    assign bd_m  = in_b_den[W-1] ? (~in_b_den + 1'b1) : in_b_den;
    assign as_s  = in_a_num[W-1] ^ in_a_den[W-1];
    assign bs_s  = in_b_num[W-1] ^ in_b_den[W-1];

    // first product: a_num term, second: a_den term
    always_comb
    begin
        case (op_reg)
            rmdr_pkg::OP_REDUCE:
            begin
                mx = cmd.mul_first ? an_reg : ad_reg;
                my = W'(1);
            end
            rmdr_pkg::OP_MUL:
            begin
                mx = cmd.mul_first ? an_reg : ad_reg;
                my = cmd.mul_first ? bn_reg : bd_reg;
            end
            default:
            begin
                mx = cmd.mul_first ? an_reg : ad_reg;
                my = cmd.mul_first ? bd_reg : bn_reg;
            end
        endcase
    end

    assign prod  = PW'(mx) * PW'(my);
    assign rn_sh = {rn_reg, p_reg[PW-1]};
    assign rd_sh = {rd_reg, q_reg[PW-1]};
    assign bit_n = (rn_sh >= {1'b0, g_reg});
    assign bit_d = (rd_sh >= {1'b0, g_reg});

    assign r_neg = neg_reg && (p_reg != '0);
    assign r_ovf = (q_reg > LIMIT - 1'b1) || (p_reg > (r_neg ? LIMIT : LIMIT - 1'b1));

    assign sts.zero_den = zero_reg;
    assign sts.is_eq    = (op_reg == rmdr_pkg::OP_EQ);
    assign sts.gcd_done = (u_reg == '0);
    assign sts.div_done = (cnt_reg == '1);
    assign sts.out_free = !valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_op;
            an_reg      <= an_m;
            ad_reg      <= ad_m;
            bn_reg      <= bn_m;
            bd_reg      <= bd_m;
            neg_reg     <= (in_op == rmdr_pkg::OP_REDUCE) ? as_s : (as_s ^ bs_s);
            sign_ok_reg <= (an_m == '0) || (as_s == bs_s);
            zero_reg    <= (ad_m == '0)
                        || ((in_op != rmdr_pkg::OP_REDUCE) && (bd_m == '0))
                        || ((in_op == rmdr_pkg::OP_DIV) && (bn_m == '0));
        end
        if (cmd.mul_first)
        begin
            p_reg <= prod;
        end
        if (cmd.mul_second)
        begin
            q_reg <= prod;
        end
        if (cmd.gcd_init)
        begin
            u_reg <= p_reg;
            v_reg <= q_reg;
            k_reg <= '0;
        end
        if (cmd.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg >= v_reg)
            begin
                u_reg <= u_reg - v_reg;
            end
            else
            begin
                v_reg <= v_reg - u_reg;
            end
        end
        if (cmd.div_init)
        begin
            g_reg   <= v_reg << k_reg;
            rn_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            // quotient bits shift into the dividend registers
            rn_reg  <= bit_n ? PW'(rn_sh - {1'b0, g_reg}) : rn_sh[PW-1:0];
            rd_reg  <= bit_d ? PW'(rd_sh - {1'b0, g_reg}) : rd_sh[PW-1:0];
            p_reg   <= {p_reg[PW-2:0], bit_n};
            q_reg   <= {q_reg[PW-2:0], bit_d};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            num_reg    <= '0;
            den_reg    <= '0;
            eq_reg     <= 1'b0;
            status_reg <= rmdr_pkg::ST_OK;
            if (zero_reg)
            begin
                status_reg <= rmdr_pkg::ST_ZERO_DEN;
            end
            else if (op_reg == rmdr_pkg::OP_EQ)
            begin
                eq_reg <= (p_reg == q_reg) && sign_ok_reg;
            end
            else if (r_ovf)
            begin
                status_reg <= rmdr_pkg::ST_OVERFLOW;
            end
            else
            begin
                num_reg <= r_neg ? (~p_reg[31:0] + 1'b1) : p_reg[31:0];
                den_reg <= q_reg[30:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid  = valid_reg;
    assign out_num    = num_reg;
    assign out_den    = den_reg;
    assign out_eq     = eq_reg;
    assign out_status = status_reg;

`ifndef SYNTHESIS
    a_gcd_v_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |-> (v_reg != '0))
        else $error("gcd operand v reached zero");
    a_rem_below_g: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rn_reg < g_reg) && (rd_reg < g_reg))
        else $error("divider remainder not below divisor");
    a_err_clears_data: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg != rmdr_pkg::ST_OK) |-> (den_reg == '0) && !eq_reg)
        else $error("error result carries data");
`endif

endmodule

`default_nettype wire
